// File: design/m3i_pkg.sv
// Shared types and constants for the 3x3 matrix inverse pipeline.
// No dependencies.
`timescale 1ns / 1ps
package m3i_pkg;

  localparam int ELEM_W = 32;
  localparam int FRAC_W = 16;

  typedef logic signed [ELEM_W-1:0] elem_t;

  typedef struct packed {
    elem_t m00;
    elem_t m01;
    elem_t m02;
    elem_t m10;
    elem_t m11;
    elem_t m12;
    elem_t m20;
    elem_t m21;
    elem_t m22;
  } mat_in_t;

  typedef struct packed {
    elem_t inv00;
    elem_t inv01;
    elem_t inv02;
    elem_t inv10;
    elem_t inv11;
    elem_t inv12;
    elem_t inv20;
    elem_t inv21;
    elem_t inv22;
    elem_t determinant;
    logic  singular;
  } mat_out_t;

endpackage

// File: design/m3i_cof.sv
// Cofactor stages: eighteen minor products, then difference, scale and saturate.
// Depends on m3i_pkg.
`timescale 1ns / 1ps
module m3i_cof
  import m3i_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_W
) (
  input  logic    clk,
  input  logic    en,
  input  mat_in_t mat,
  output elem_t   cof [9],
  output elem_t   row0 [3]
);

  localparam int PW = 2 * ELEM_W;

  elem_t e [9];
  logic signed [PW-1:0] pa [9];
  logic signed [PW-1:0] pb [9];
  elem_t row0_q [3];

  assign e[0] = mat.m00;
  assign e[1] = mat.m01;
  assign e[2] = mat.m02;
  assign e[3] = mat.m10;
  assign e[4] = mat.m11;
  assign e[5] = mat.m12;
  assign e[6] = mat.m20;
  assign e[7] = mat.m21;
  assign e[8] = mat.m22;

  for (genvar i = 0; i < 9; i++) begin : g_cof
    localparam int ROW = i / 3;
    localparam int COL = i % 3;
    localparam int R0 = (ROW == 0) ? 1 : 0;
    localparam int R1 = (ROW == 2) ? 1 : 2;
    localparam int C0 = (COL == 0) ? 1 : 0;
    localparam int C1 = (COL == 2) ? 1 : 2;
    localparam bit ODD = ((ROW + COL) % 2) == 1;

    logic signed [PW:0] diff;
    logic signed [PW:0] sh;
    logic fits;

    always_ff @(posedge clk) begin
      if (en) begin
        pa[i] <= e[R0*3+C0] * e[R1*3+C1];
        pb[i] <= e[R0*3+C1] * e[R1*3+C0];
      end
    end

    always_comb begin
      if (ODD) begin
        diff = $signed({pb[i][PW-1], pb[i]}) - $signed({pa[i][PW-1], pa[i]});
      end else begin
        diff = $signed({pa[i][PW-1], pa[i]}) - $signed({pb[i][PW-1], pb[i]});
      end
      sh = diff >>> FRAC_BITS;
      fits = (&sh[PW:ELEM_W-1]) | ~(|sh[PW:ELEM_W-1]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (fits) begin
          cof[i] <= sh[ELEM_W-1:0];
        end else if (sh[PW]) begin
          cof[i] <= {1'b1, {(ELEM_W-1){1'b0}}};
        end else begin
          cof[i] <= {1'b0, {(ELEM_W-1){1'b1}}};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row0_q[0] <= e[0];
      row0_q[1] <= e[1];
      row0_q[2] <= e[2];
      row0 <= row0_q;
    end
  end

endmodule

// File: design/m3i_det.sv
// Determinant stages: first-row products, then sum, scale and saturate.
// Depends on m3i_pkg; carries the cofactors alongside.
`timescale 1ns / 1ps
module m3i_det
  import m3i_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_W
) (
  input  logic  clk,
  input  logic  en,
  input  elem_t cof [9],
  input  elem_t row0 [3],
  output elem_t cof_d [9],
  output elem_t det
);

  localparam int PW = 2 * ELEM_W;

  logic signed [PW-1:0] p [3];
  logic signed [PW+1:0] sum;
  logic signed [PW+1:0] sh;
  logic fits;
  elem_t cof_q [9];

  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= row0[0] * cof[0];
      p[1] <= row0[1] * cof[1];
      p[2] <= row0[2] * cof[2];
      cof_q <= cof;
      cof_d <= cof_q;
    end
  end

  always_comb begin
    sum = $signed({{2{p[0][PW-1]}}, p[0]}) + $signed({{2{p[1][PW-1]}}, p[1]})
        + $signed({{2{p[2][PW-1]}}, p[2]});
    sh = sum >>> FRAC_BITS;
    fits = (&sh[PW+1:ELEM_W-1]) | ~(|sh[PW+1:ELEM_W-1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (fits) begin
        det <= sh[ELEM_W-1:0];
      end else if (sh[PW+1]) begin
        det <= {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
        det <= {1'b0, {(ELEM_W-1){1'b1}}};
      end
    end
  end

endmodule

// File: design/m3i_div.sv
// Pipelined restoring divider, one quotient bit per stage, truncating and saturating.
// Depends on m3i_pkg. A zero divisor gives a zero quotient.
`timescale 1ns / 1ps
module m3i_div
  import m3i_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_W
) (
  input  logic  clk,
  input  logic  en,
  input  elem_t num,
  input  elem_t den,
  output elem_t quo
);

  localparam int NW = ELEM_W + FRAC_BITS;

  logic [ELEM_W-1:0] nm [NW+1];
  logic [ELEM_W-1:0] dm [NW+1];
  logic [ELEM_W-1:0] rem [NW+1];
  logic [NW-1:0]     q [NW+1];
  logic              neg [NW+1];
  logic [NW-1:0]     lim;
  logic              zero_den;

  assign zero_den = (den == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      nm[0] <= zero_den ? '0 : (num[ELEM_W-1] ? ELEM_W'(-num) : num);
      dm[0] <= zero_den ? ELEM_W'(1) : (den[ELEM_W-1] ? ELEM_W'(-den) : den);
      neg[0] <= num[ELEM_W-1] ^ den[ELEM_W-1];
      rem[0] <= '0;
      q[0] <= '0;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_stage
    localparam int B = NW - 1 - k;
    logic nbit;
    logic [ELEM_W:0] trial;
    logic ge;

    if (B >= FRAC_BITS) begin : g_nb
      assign nbit = nm[k][B-FRAC_BITS];
    end else begin : g_zb
      assign nbit = 1'b0;
    end

    assign trial = {rem[k], nbit};
    assign ge = trial >= {1'b0, dm[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? ELEM_W'(trial - {1'b0, dm[k]}) : trial[ELEM_W-1:0];
        q[k+1] <= {q[k][NW-2:0], ge};
        nm[k+1] <= nm[k];
        dm[k+1] <= dm[k];
        neg[k+1] <= neg[k];
      end
    end
  end

  assign lim = neg[NW] ? (NW'(1) << (ELEM_W - 1)) : ((NW'(1) << (ELEM_W - 1)) - NW'(1));

  always_ff @(posedge clk) begin
    if (en) begin
      if (q[NW] > lim) begin
        quo <= neg[NW] ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
      end else if (neg[NW]) begin
        quo <= ELEM_W'(-q[NW]);
      end else begin
        quo <= q[NW][ELEM_W-1:0];
      end
    end
  end

endmodule

// File: design/matrix3x3_inverse.sv
// Top level of the 3x3 matrix inverse pipeline (adjugate over determinant).
// Depends on m3i_pkg, m3i_cof, m3i_det and m3i_div.
//
// Usage:
//   Input channel mat_valid / mat_stall / mat carries one matrix per beat,
//   nine signed Q16.16 elements in row-major order.
//   Output channel inv_valid / inv_stall / inv carries the inverse, the
//   determinant and the singular flag. A zero determinant gives a zeroed
//   inverse and singular set; overflowing values saturate.
//   Throughput: one matrix per cycle while no result waits under inv_stall.
//   Stages (Q16.16 by default): two cofactor, two determinant, one divider
//   setup stage, one stage per quotient bit and one saturation stage.
//   The whole pipeline advances as one; when a result waits under inv_stall
//   every stage holds and mat_stall rises in the same cycle.
//   Reset clears the valid bits of all stages; data registers are not reset.
`timescale 1ns / 1ps
module matrix3x3_inverse
  import m3i_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_W
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     mat_valid,
  output logic     mat_stall,
  input  mat_in_t  mat,
  output logic     inv_valid,
  input  logic     inv_stall,
  output mat_out_t inv
);

  localparam int NW = ELEM_W + FRAC_BITS;
  localparam int DL = NW + 2;
  localparam int LAT = 4 + DL;

  logic en;
  logic [LAT-1:0] vld;
  elem_t cof [9];
  elem_t row0 [3];
  elem_t cof_d [9];
  elem_t det;
  elem_t det_line [DL];
  elem_t q [9];

  assign en = !(inv_valid && inv_stall);
  assign mat_stall = !en;
  assign inv_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], mat_valid};
    end
  end

  m3i_cof #(.FRAC_BITS(FRAC_BITS)) u_cof (
    .clk(clk), .en(en), .mat(mat), .cof(cof), .row0(row0)
  );

  m3i_det #(.FRAC_BITS(FRAC_BITS)) u_det (
    .clk(clk), .en(en), .cof(cof), .row0(row0), .cof_d(cof_d), .det(det)
  );

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      m3i_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .en(en), .num(cof_d[c*3+r]), .den(det), .quo(q[r*3+c])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_line[0] <= det;
      for (int i = 1; i < DL; i++) begin
        det_line[i] <= det_line[i-1];
      end
    end
  end

  assign inv.inv00 = q[0];
  assign inv.inv01 = q[1];
  assign inv.inv02 = q[2];
  assign inv.inv10 = q[3];
  assign inv.inv11 = q[4];
  assign inv.inv12 = q[5];
  assign inv.inv20 = q[6];
  assign inv.inv21 = q[7];
  assign inv.inv22 = q[8];
  assign inv.determinant = det_line[DL-1];
  assign inv.singular = (det_line[DL-1] == '0);

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    inv_valid && inv.singular |-> inv.inv00 == '0 && inv.inv11 == '0 && inv.inv22 == '0)
    else $error("singular result with nonzero inverse");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    mat_valid && !mat_stall |=> vld[0])
    else $error("accepted beat did not enter pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    mat_stall |=> $stable(vld[LAT-2:0]))
    else $error("pipeline moved under stall");

endmodule

// File: tb/m3i_checker.sv
// Checker for matrix3x3_inverse: watches both channels, predicts each inverse
// from the accepted matrix and compares results field by field. Depends on m3i_pkg.
`timescale 1ns / 1ps
module m3i_checker
  import m3i_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     mat_valid,
  input  logic     mat_stall,
  input  mat_in_t  mat,
  input  logic     inv_valid,
  input  logic     inv_stall,
  input  mat_out_t inv,
  output int       fail_count,
  output int       pending
);

  typedef logic signed [127:0] wide_t;

  localparam wide_t ELEM_MAX = (128'sd1 <<< (ELEM_W - 1)) - 128'sd1;
  localparam wide_t ELEM_MIN = -(128'sd1 <<< (ELEM_W - 1));

  mat_out_t expected_inv_q[$];

  function automatic elem_t clamp_elem(wide_t v);
    if (v > ELEM_MAX) return elem_t'(ELEM_MAX);
    if (v < ELEM_MIN) return elem_t'(ELEM_MIN);
    return elem_t'(v);
  endfunction

  function automatic mat_out_t invert_matrix(mat_in_t m);
    wide_t e[9];
    wide_t acc, minor, num, det_w;
    elem_t cof[9];
    elem_t det;
    mat_out_t res;
    int row, col, r0, r1, c0, c1;
    e[0] = m.m00; e[1] = m.m01; e[2] = m.m02;
    e[3] = m.m10; e[4] = m.m11; e[5] = m.m12;
    e[6] = m.m20; e[7] = m.m21; e[8] = m.m22;
    for (int p = 0; p < 9; p++) begin
      row = p / 3;
      col = p % 3;
      r0 = (row == 0) ? 1 : 0;
      r1 = (row == 2) ? 1 : 2;
      c0 = (col == 0) ? 1 : 0;
      c1 = (col == 2) ? 1 : 2;
      minor = e[r0*3+c0] * e[r1*3+c1] - e[r0*3+c1] * e[r1*3+c0];
      if ((row + col) % 2 == 1) minor = -minor;
      cof[p] = clamp_elem(minor >>> FRAC_W);
    end
    acc = 0;
    for (int j = 0; j < 3; j++) begin
      acc = acc + e[j] * wide_t'(cof[j]);
    end
    det = clamp_elem(acc >>> FRAC_W);
    det_w = det;
    res = '0;
    res.determinant = det;
    if (det == 0) begin
      res.singular = 1'b1;
      return res;
    end
    for (int k = 0; k < 9; k++) begin
      num = wide_t'(cof[(k % 3) * 3 + k / 3]) <<< FRAC_W;
      res[320 - 32*k -: 32] = clamp_elem(num / det_w);
    end
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    fail_count++;
  endtask

  string field_names[10] = '{"inv00", "inv01", "inv02", "inv10", "inv11", "inv12",
                             "inv20", "inv21", "inv22", "determinant"};

  initial fail_count = 0;
  assign pending = expected_inv_q.size();

  always @(posedge clk) begin
    mat_out_t want;
    if (!rst) begin
      if (mat_valid && !mat_stall) expected_inv_q.push_back(invert_matrix(mat));
      if (inv_valid && !inv_stall) begin
        if (expected_inv_q.size() == 0) begin
          $display("%0t result beat with nothing expected", $realtime);
          fail_count++;
        end else begin
          want = expected_inv_q.pop_front();
          for (int k = 0; k < 10; k++) begin
            if (inv[320 - 32*k -: 32] !== want[320 - 32*k -: 32])
              report_mismatch(field_names[k], inv[320 - 32*k -: 32],
                              want[320 - 32*k -: 32]);
          end
          if (inv.singular !== want.singular)
            report_mismatch("singular", 32'(inv.singular), 32'(want.singular));
        end
      end
    end
  end

endmodule

// File: tb/tb_top.sv
// Testbench top, depends on m3i_pkg, m3i_checker and matrix3x3_inverse: drives
// directed and random matrices with random idling on both channels, gives the verdict.
`timescale 1ns / 1ps
module tb_top
  import m3i_pkg::*;
();

  localparam int RANDOM_ITEMS = 1350;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 80;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     mat_valid = 1'b0;
  logic     mat_stall;
  mat_in_t  mat = '0;
  logic     inv_valid;
  logic     inv_stall = 1'b0;
  mat_out_t inv;
  int       fail_count;
  int       pending;
  int       cycles = 0;
  bit       no_idle = 1'b0;

  matrix3x3_inverse i_dut (
    .clk(clk), .rst(rst),
    .mat_valid(mat_valid), .mat_stall(mat_stall), .mat(mat),
    .inv_valid(inv_valid), .inv_stall(inv_stall), .inv(inv)
  );

  m3i_checker i_checker (
    .clk(clk), .rst(rst),
    .mat_valid(mat_valid), .mat_stall(mat_stall), .mat(mat),
    .inv_valid(inv_valid), .inv_stall(inv_stall), .inv(inv),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    inv_stall <= !no_idle && ($urandom_range(99) < 18);
  end

  function automatic elem_t pick_elem(int mode);
    elem_t extremes[8] = '{32'sh0, 32'sh80000000, 32'sh7fffffff, 32'sh00010000,
                           -32'sh00010000, 32'sh1, -32'sh1, 32'sh00008000};
    case (mode)
      0: return elem_t'($signed($urandom_range(524288)) - 262144);
      1: return elem_t'($urandom);
      default: return extremes[$urandom_range(7)];
    endcase
  endfunction

  function automatic mat_in_t random_matrix();
    mat_in_t m;
    int mode, sel;
    sel = $urandom_range(99);
    mode = (sel < 50) ? 0 : (sel < 70) ? 1 : 2;
    for (int k = 0; k < 9; k++) m[287 - 32*k -: 32] = pick_elem(mode);
    if (sel >= 85) begin
      case ($urandom_range(2))
        0: begin m.m10 = m.m00; m.m11 = m.m01; m.m12 = m.m02; end
        1: begin m.m02 = m.m00; m.m12 = m.m10; m.m22 = m.m20; end
        default: begin m.m20 = '0; m.m21 = '0; m.m22 = '0; end
      endcase
    end
    return m;
  endfunction

  task automatic send_matrix(mat_in_t m, bit may_idle);
    while (may_idle && !no_idle && $urandom_range(99) < 18) begin
      mat_valid <= 1'b0;
      @(posedge clk);
    end
    mat_valid <= 1'b1;
    mat <= m;
    forever begin
      @(negedge clk);
      if (!mat_stall) break;
    end
    @(posedge clk);
  endtask

  function automatic mat_in_t make_matrix(elem_t a, elem_t b, elem_t c, elem_t d,
                                          elem_t e, elem_t f, elem_t g, elem_t h,
                                          elem_t i);
    mat_in_t m;
    m.m00 = a; m.m01 = b; m.m02 = c;
    m.m10 = d; m.m11 = e; m.m12 = f;
    m.m20 = g; m.m21 = h; m.m22 = i;
    return m;
  endfunction

  initial begin
    mat_in_t directed_mats[$];
    elem_t one, mx, mn;
    one = 32'sh00010000;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    directed_mats.push_back(make_matrix(one, 0, 0, 0, one, 0, 0, 0, one));
    directed_mats.push_back(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_mats.push_back(make_matrix(mx, mx, mx, mx, mx, mx, mx, mx, mx));
    directed_mats.push_back(make_matrix(mn, mn, mn, mn, mn, mn, mn, mn, mn));
    directed_mats.push_back(make_matrix(mx, 0, 0, 0, mx, 0, 0, 0, mx));
    directed_mats.push_back(make_matrix(mn, 0, 0, 0, mn, 0, 0, 0, mn));
    directed_mats.push_back(make_matrix(mn, mn, 0, 0, mn, mx, mx, 0, mn));
    directed_mats.push_back(make_matrix(mx, mn, mx, mn, mx, mn, mx, mn, mx));
    directed_mats.push_back(make_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
    directed_mats.push_back(make_matrix(-1, 0, 0, 0, -1, 0, 0, 0, -1));
    directed_mats.push_back(make_matrix(2*one, 0, 0, 0, 2*one, 0, 0, 0, 2*one));
    directed_mats.push_back(make_matrix(one, 2*one, 3*one, 4*one, 5*one, 6*one,
                                        7*one, 8*one, 9*one));
    directed_mats.push_back(make_matrix(2*one, -one, 0, -one, 2*one, -one,
                                        0, -one, 2*one));
    directed_mats.push_back(make_matrix(0, one, 0, one, 0, 0, 0, 0, one));
    directed_mats.push_back(make_matrix(0, 0, one, 0, one, 0, one, 0, 0));
    directed_mats.push_back(make_matrix(mn, 0, 0, 0, one, mn, 0, one, mx));
    directed_mats.push_back(make_matrix(0, mn, 0, mn, 0, 0, 0, 0, mn));
    directed_mats.push_back(make_matrix(one, 0, 0, 0, 0, mn, 0, one, 0));
    directed_mats.push_back(make_matrix(32'sh100, 0, 0, 0, 32'sh100, 0, 0, 0,
                                        32'sh100));
    directed_mats.push_back(make_matrix(one >>> 8, 0, 0, 0, one, 0, 0, 0, one));
    directed_mats.push_back(make_matrix(32'sh00008000, 0, 0, 0, 32'sh00008000, 0,
                                        0, 0, 32'sh00008000));
    directed_mats.push_back(make_matrix(32'sh12345678, -32'sh0abcdef0, 32'sh0f0f0f0f,
                                        32'sh5a5a5a5a, -32'sh3c3c3c3c, 32'sh7f00ff00,
                                        -32'sh0000ffff, 32'sh00ff00ff, -32'sh5555aaaa));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_mats[k]) send_matrix(directed_mats[k], 1'b1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 400) no_idle = 1'b1;
      if (n == 700) no_idle = 1'b0;
      if (n == 900) begin
        mat_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      send_matrix(random_matrix(), 1'b1);
    end
    mat_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/m3i_pkg.sv
design/m3i_cof.sv
design/m3i_det.sv
design/m3i_div.sv
design/matrix3x3_inverse.sv
tb/m3i_checker.sv
tb/tb_top.sv
